// ===== src/ubac_pkg.sv =====
package ubac_pkg;

  localparam int unsigned MaxResults = 7;

  // opcodes
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SENSOR = 2'd2;

  // config register indexes
  localparam logic [2:0] CFG_BEEP_ON   = 3'd0;
  localparam logic [2:0] CFG_BEEP_OFF  = 3'd1;
  localparam logic [2:0] CFG_ALARM_MAX = 3'd2;
  localparam logic [2:0] CFG_HELLO     = 3'd3;
  localparam logic [2:0] CFG_DUTY      = 3'd4;
  localparam logic [2:0] CFG_CHIME_ON  = 3'd5;
  localparam logic [2:0] CFG_CHIME_OFF = 3'd6;

  // config reset values
  localparam logic [15:0] BEEP_ON_RST   = 16'd250;
  localparam logic [15:0] BEEP_OFF_RST  = 16'd180;
  localparam logic [19:0] ALARM_MAX_RST = 20'd300000;
  localparam logic [15:0] HELLO_RST     = 16'd10000;
  localparam logic [39:0] DUTY_RST      = 40'd547396800572;
  localparam logic [7:0]  CHIME_ON_RST  = 8'd90;
  localparam logic [7:0]  CHIME_OFF_RST = 8'd20;

  // frame bytes and commands
  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] ACK_BYTE   = 8'hAA;
  localparam logic [7:0] HELLO_BYTE = 8'hEE;
  localparam logic [7:0] CMD_START  = 8'h01;
  localparam logic [7:0] CMD_STOP   = 8'h02;
  localparam logic [7:0] CMD_CHIME  = 8'h03;
  localparam logic [7:0] CMD_VOL1   = 8'h11;
  localparam logic [7:0] CMD_VOL5   = 8'h15;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_PING   = 8'hF0;

  localparam logic [15:0] TEMP_NONE = 16'h8000;
  localparam logic [13:0] HUM_MAX   = 14'd10000;
  localparam logic [2:0]  VOL_RST   = 3'd2;

endpackage

// ===== src/uart_buzzer_alarm_controller.sv =====
// Alarm buzzer controller with a framed serial command link.
// Input channel (in_valid_i / in_stall_o): one item per accept, opcode_i
// selects a received byte, a millisecond tick or a sensor reading.
// Output channel (out_valid_o / out_stall_i): one to seven results per item,
// last_o marks the final one; every result carries the buzzer duty and the
// alarm flag as they stand after the item.
// Config channel (cfg_valid_i / cfg_ready_o): always ready, write only while
// the block is idle.
// The first result of an item goes through the result buffer and then the
// output register. The buffer frees when an item's last result is popped,
// so single-result items flow at one per cycle while the receiver does not
// stall; a read reply has seven results, a beacon three.
// The result buffer holds one item's burst and the output register one
// result, so a stalled receiver holds one more item before in_stall_o rises.
// Reset: all state and config registers return to their defaults, the
// buffer and output register empty; the first tick sends a beacon.
module uart_buzzer_alarm_controller
  import ubac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               sensor_ok_i,
  input  logic signed [15:0] temp_centi_i,
  input  logic [15:0]        hum_centi_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               tx_valid_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_o,
  output logic [7:0]         buzzer_duty_o,
  output logic               alarm_on_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [39:0]        cfg_data_i
);

  localparam logic [1:0] CH_IDLE = 2'd0;
  localparam logic [1:0] CH_ON   = 2'd1;
  localparam logic [1:0] CH_OFF  = 2'd2;

  localparam logic [1:0] FP_IDLE = 2'd0;
  localparam logic [1:0] FP_CMD  = 2'd1;
  localparam logic [1:0] FP_SUM  = 2'd2;

  // config
  logic [15:0] beep_on_q, beep_off_q, hello_per_q;
  logic [19:0] alarm_max_q;
  logic [39:0] duty_tab_q;
  logic [7:0]  chime_on_q, chime_off_q;

  // state
  logic [1:0]  fp_q, fp_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        alarm_q, alarm_d;
  logic        beep_q, beep_d;
  logic [2:0]  vol_q, vol_d;
  logic [19:0] ae_q, ae_d;
  logic [15:0] te_q, te_d;
  logic [15:0] he_q, he_d;
  logic        hfirst_q, hfirst_d;
  logic [1:0]  ph_q, ph_d;
  logic [7:0]  ccnt_q, ccnt_d;
  logic [15:0] temp_q, temp_d;
  logic [13:0] hum_q, hum_d;

  // result buffer
  logic [7:0]  buf_q [MaxResults];
  logic [7:0]  buf_d [MaxResults];
  logic [2:0]  cnt_q, txn;
  logic        txv_q;
  logic [7:0]  bduty_q, duty_d;
  logic        balarm_q;

  logic        accept, pop, settle;
  logic [15:0] beep_lim;
  logic [7:0]  chime_lim, ccnt_inc, chk;
  logic [2:0]  vsel;

  assign cfg_ready_o = 1'b1;
  assign pop         = (cnt_q != 3'd0) && (!out_valid_o || !out_stall_i);
  assign in_stall_o  = !((cnt_q == 3'd0) || ((cnt_q == 3'd1) && pop));
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    fp_d     = fp_q;
    cmd_d    = cmd_q;
    alarm_d  = alarm_q;
    beep_d   = beep_q;
    vol_d    = vol_q;
    ae_d     = ae_q;
    te_d     = te_q;
    he_d     = he_q;
    hfirst_d = hfirst_q;
    ph_d     = ph_q;
    ccnt_d   = ccnt_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    settle   = 1'b0;
    txn      = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      buf_d[i] = 8'h00;
    end
    beep_lim  = beep_q ? beep_on_q : beep_off_q;
    chime_lim = (ph_q == CH_ON) ? chime_on_q : chime_off_q;
    ccnt_inc  = ccnt_q + 8'd1;
    chk       = SOF_BYTE ^ CMD_READ ^ temp_q[15:8] ^ temp_q[7:0] ^
                {2'b00, hum_q[13:8]} ^ hum_q[7:0];

    unique case (opcode_i)
      OP_BYTE: begin
        if (fp_q == FP_CMD) begin
          cmd_d = rx_byte_i;
          fp_d  = FP_SUM;
        end else if (fp_q == FP_SUM) begin
          fp_d = FP_IDLE;
          if (rx_byte_i == (SOF_BYTE ^ cmd_q)) begin
            if (cmd_q == CMD_START || (cmd_q >= CMD_VOL1 && cmd_q <= CMD_VOL5)) begin
              vol_d   = (cmd_q == CMD_START) ? VOL_RST : cmd_q[2:0];
              alarm_d = 1'b1;
              ae_d    = '0;
              te_d    = '0;
              beep_d  = 1'b1;
              txn     = 3'd1;
              buf_d[0] = ACK_BYTE;
            end else if (cmd_q == CMD_STOP) begin
              alarm_d  = 1'b0;
              beep_d   = 1'b0;
              txn      = 3'd1;
              buf_d[0] = ACK_BYTE;
            end else if (cmd_q == CMD_CHIME) begin
              ph_d     = CH_ON;
              ccnt_d   = '0;
              settle   = 1'b1;
              txn      = 3'd1;
              buf_d[0] = ACK_BYTE;
            end else if (cmd_q == CMD_PING) begin
              txn      = 3'd1;
              buf_d[0] = ACK_BYTE;
            end else if (cmd_q == CMD_READ) begin
              txn      = 3'd7;
              buf_d[0] = SOF_BYTE;
              buf_d[1] = CMD_READ;
              buf_d[2] = temp_q[15:8];
              buf_d[3] = temp_q[7:0];
              buf_d[4] = {2'b00, hum_q[13:8]};
              buf_d[5] = hum_q[7:0];
              buf_d[6] = chk;
            end
          end
        end else begin
          fp_d = (rx_byte_i == SOF_BYTE) ? FP_CMD : FP_IDLE;
        end
      end
      OP_TICK: begin
        if (hfirst_q || he_q >= hello_per_q) begin
          hfirst_d = 1'b0;
          he_d     = '0;
          txn      = 3'd3;
          buf_d[0] = SOF_BYTE;
          buf_d[1] = HELLO_BYTE;
          buf_d[2] = SOF_BYTE ^ HELLO_BYTE;
        end else begin
          he_d = he_q + 16'd1;
        end
        if (alarm_q) begin
          if (ae_q >= alarm_max_q) begin
            alarm_d = 1'b0;
            beep_d  = 1'b0;
          end else begin
            ae_d = ae_q + 20'd1;
            if (te_q >= beep_lim) begin
              te_d   = '0;
              beep_d = !beep_q;
            end else begin
              te_d = te_q + 16'd1;
            end
          end
        end
        if (ph_q == CH_ON || ph_q == CH_OFF) begin
          ccnt_d = ccnt_inc;
          if (ccnt_inc >= chime_lim) begin
            ph_d   = (ph_q == CH_ON) ? CH_OFF : CH_IDLE;
            ccnt_d = '0;
          end
        end
        settle = 1'b1;
      end
      OP_SENSOR: begin
        if (sensor_ok_i) begin
          temp_d = temp_centi_i;
          hum_d  = (hum_centi_i > 16'(HUM_MAX)) ? HUM_MAX : hum_centi_i[13:0];
        end else begin
          temp_d = TEMP_NONE;
          hum_d  = '0;
        end
      end
      default: begin
      end
    endcase

    if (settle) begin
      if (ph_d == CH_ON && chime_on_q == 8'd0) begin
        ph_d   = CH_OFF;
        ccnt_d = '0;
      end
      if (ph_d == CH_OFF && chime_off_q == 8'd0) begin
        ph_d   = CH_IDLE;
        ccnt_d = '0;
      end
      if (ph_d != CH_IDLE && ph_d != CH_ON && ph_d != CH_OFF) begin
        ph_d   = CH_IDLE;
        ccnt_d = '0;
      end
    end

    vsel = vol_d;
    if (vsel < 3'd1) vsel = 3'd1;
    if (vsel > 3'd5) vsel = 3'd5;

    priority if (ph_d == CH_ON) begin
      duty_d = 8'h00;
      unique case (vsel)
        3'd1:    duty_d = duty_tab_q[7:0];
        3'd2:    duty_d = duty_tab_q[15:8];
        3'd3:    duty_d = duty_tab_q[23:16];
        3'd4:    duty_d = duty_tab_q[31:24];
        default: duty_d = duty_tab_q[39:32];
      endcase
    end else if (ph_d == CH_OFF) begin
      duty_d = 8'h00;
    end else if (alarm_d && beep_d) begin
      unique case (vsel)
        3'd1:    duty_d = duty_tab_q[7:0];
        3'd2:    duty_d = duty_tab_q[15:8];
        3'd3:    duty_d = duty_tab_q[23:16];
        3'd4:    duty_d = duty_tab_q[31:24];
        default: duty_d = duty_tab_q[39:32];
      endcase
    end else begin
      duty_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_on_q   <= BEEP_ON_RST;
      beep_off_q  <= BEEP_OFF_RST;
      alarm_max_q <= ALARM_MAX_RST;
      hello_per_q <= HELLO_RST;
      duty_tab_q  <= DUTY_RST;
      chime_on_q  <= CHIME_ON_RST;
      chime_off_q <= CHIME_OFF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BEEP_ON:   beep_on_q   <= cfg_data_i[15:0];
        CFG_BEEP_OFF:  beep_off_q  <= cfg_data_i[15:0];
        CFG_ALARM_MAX: alarm_max_q <= cfg_data_i[19:0];
        CFG_HELLO:     hello_per_q <= cfg_data_i[15:0];
        CFG_DUTY:      duty_tab_q  <= cfg_data_i;
        CFG_CHIME_ON:  chime_on_q  <= cfg_data_i[7:0];
        CFG_CHIME_OFF: chime_off_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q     <= FP_IDLE;
      cmd_q    <= '0;
      alarm_q  <= 1'b0;
      beep_q   <= 1'b0;
      vol_q    <= VOL_RST;
      ae_q     <= '0;
      te_q     <= '0;
      he_q     <= '0;
      hfirst_q <= 1'b1;
      ph_q     <= CH_IDLE;
      ccnt_q   <= '0;
      temp_q   <= TEMP_NONE;
      hum_q    <= '0;
    end else if (accept) begin
      fp_q     <= fp_d;
      cmd_q    <= cmd_d;
      alarm_q  <= alarm_d;
      beep_q   <= beep_d;
      vol_q    <= vol_d;
      ae_q     <= ae_d;
      te_q     <= te_d;
      he_q     <= he_d;
      hfirst_q <= hfirst_d;
      ph_q     <= ph_d;
      ccnt_q   <= ccnt_d;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
    end
  end

  // result buffer: head at index 0, shifts on each pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= (txn == 3'd0) ? 3'd1 : txn;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q    <= buf_d;
      txv_q    <= (txn != 3'd0);
      bduty_q  <= duty_d;
      balarm_q <= alarm_d;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[MaxResults-1] <= 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (pop) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      tx_valid_o    <= txv_q;
      tx_byte_o     <= txv_q ? buf_q[0] : 8'h00;
      last_o        <= (cnt_q == 3'd1);
      buzzer_duty_o <= bduty_q;
      alarm_on_o    <= balarm_q;
    end
  end

endmodule

// ===== src/ubac_checker.sv =====
module ubac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               tx_valid_o,
  input logic [7:0]         tx_byte_o,
  input logic               last_o,
  input logic [7:0]         buzzer_duty_o,
  input logic               alarm_on_o,
  input logic               cfg_ready_o
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o) && $stable(last_o)
      && $stable(tx_valid_o))
    else $error("stalled result changed");

  // an item with nothing to send gives a single zero result
  a_silent_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> last_o && (tx_byte_o == 8'h00))
    else $error("silent result malformed");

  // a burst runs without gaps and shares duty and alarm flag
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && tx_valid_o
      && $stable(buzzer_duty_o) && $stable(alarm_on_o))
    else $error("burst broken");

  // config writes are always taken
  a_ready_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config not ready");

endmodule

bind uart_buzzer_alarm_controller ubac_checker u_ubac_checker (.*);

// ===== bench/tb_uart_buzzer_alarm_controller.sv =====
module tb_uart_buzzer_alarm_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import ubac_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int StallLimit = 1000;

  typedef enum logic [1:0] {
    CHIME_IDLE  = 2'd0,
    CHIME_RING  = 2'd1,
    CHIME_QUIET = 2'd2
  } chime_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] duty;
    logic       alarm;
  } reply_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  b;
    logic        ok;
    logic [15:0] t;
    logic [15:0] h;
    logic        typed;
    reply_t      want;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = '0;
  logic [7:0]         rx_byte_i = '0;
  logic               sensor_ok_i = 1'b0;
  logic signed [15:0] temp_centi_i = '0;
  logic [15:0]        hum_centi_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               tx_valid_o;
  logic [7:0]         tx_byte_o;
  logic               last_o;
  logic [7:0]         buzzer_duty_o;
  logic               alarm_on_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [39:0]        cfg_data_i = '0;

  uart_buzzer_alarm_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .sensor_ok_i  (sensor_ok_i),
    .temp_centi_i (temp_centi_i),
    .hum_centi_i  (hum_centi_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o),
    .buzzer_duty_o(buzzer_duty_o),
    .alarm_on_o   (alarm_on_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // register copies
  logic [15:0] reg_beep_on, reg_beep_off, reg_hello;
  logic [19:0] reg_alarm_max;
  logic [39:0] reg_duty;
  logic [7:0]  reg_chime_on, reg_chime_off;

  // controller state
  logic [1:0]  frame_pos;
  logic [7:0]  cmd_hold;
  logic        alarm_run, beep_high, hello_first;
  logic [2:0]  vol;
  logic [19:0] alarm_ticks;
  logic [15:0] toggle_ticks, hello_ticks;
  chime_e      chime;
  logic [7:0]  chime_ticks;
  logic [15:0] temp_store;
  logic [13:0] hum_store;

  reply_t reply_q[$];
  stim_t  script[$];
  reply_t got, want;
  int     err_count = 0;
  int     checked = 0;
  int     items_sent = 0;
  int     settings_used = 1;
  int     idle_cycles = 0;
  int     stall_left = 0;
  int     hold;
  bit     steady_tx = 1'b0;
  bit     steady_rx = 1'b0;

  task automatic chime_skip_empty();
    if (chime == CHIME_RING && reg_chime_on == 8'd0) begin
      chime = CHIME_QUIET;
      chime_ticks = '0;
    end
    if (chime == CHIME_QUIET && reg_chime_off == 8'd0) begin
      chime = CHIME_IDLE;
      chime_ticks = '0;
    end
  endtask

  task automatic controller_step(input stim_t s);
    logic [7:0]  tx[$];
    logic [7:0]  x;
    logic [15:0] tlim;
    logic [7:0]  clim;
    logic [2:0]  v;
    logic [7:0]  duty;
    reply_t      r;
    int          n;
    case (s.op)
      OP_BYTE: begin
        if (frame_pos == 2'd1) begin
          cmd_hold = s.b;
          frame_pos = 2'd2;
        end else if (frame_pos == 2'd2) begin
          frame_pos = 2'd0;
          if (s.b == (SOF_BYTE ^ cmd_hold)) begin
            if (cmd_hold == CMD_START || (cmd_hold >= CMD_VOL1 && cmd_hold <= CMD_VOL5)) begin
              vol = (cmd_hold == CMD_START) ? VOL_RST : cmd_hold[2:0];
              alarm_run = 1'b1;
              alarm_ticks = '0;
              toggle_ticks = '0;
              beep_high = 1'b1;
              tx.push_back(ACK_BYTE);
            end else if (cmd_hold == CMD_STOP) begin
              alarm_run = 1'b0;
              beep_high = 1'b0;
              tx.push_back(ACK_BYTE);
            end else if (cmd_hold == CMD_CHIME) begin
              chime = CHIME_RING;
              chime_ticks = '0;
              chime_skip_empty();
              tx.push_back(ACK_BYTE);
            end else if (cmd_hold == CMD_PING) begin
              tx.push_back(ACK_BYTE);
            end else if (cmd_hold == CMD_READ) begin
              tx.push_back(SOF_BYTE);
              tx.push_back(CMD_READ);
              tx.push_back(temp_store[15:8]);
              tx.push_back(temp_store[7:0]);
              tx.push_back({2'b00, hum_store[13:8]});
              tx.push_back(hum_store[7:0]);
              x = '0;
              foreach (tx[i]) x = x ^ tx[i];
              tx.push_back(x);
            end
          end
        end else begin
          frame_pos = (s.b == SOF_BYTE) ? 2'd1 : 2'd0;
        end
      end
      OP_TICK: begin
        if (hello_first || hello_ticks >= reg_hello) begin
          hello_first = 1'b0;
          hello_ticks = '0;
          tx.push_back(SOF_BYTE);
          tx.push_back(HELLO_BYTE);
          tx.push_back(SOF_BYTE ^ HELLO_BYTE);
        end else begin
          hello_ticks = hello_ticks + 16'd1;
        end
        if (alarm_run) begin
          if (alarm_ticks >= reg_alarm_max) begin
            alarm_run = 1'b0;
            beep_high = 1'b0;
          end else begin
            tlim = beep_high ? reg_beep_on : reg_beep_off;
            alarm_ticks = alarm_ticks + 20'd1;
            if (toggle_ticks >= tlim) begin
              toggle_ticks = '0;
              beep_high = !beep_high;
            end else begin
              toggle_ticks = toggle_ticks + 16'd1;
            end
          end
        end
        if (chime != CHIME_IDLE) begin
          clim = (chime == CHIME_RING) ? reg_chime_on : reg_chime_off;
          chime_ticks = chime_ticks + 8'd1;
          if (chime_ticks >= clim) begin
            chime = (chime == CHIME_RING) ? CHIME_QUIET : CHIME_IDLE;
            chime_ticks = '0;
          end
        end
        chime_skip_empty();
      end
      OP_SENSOR: begin
        if (s.ok) begin
          temp_store = s.t;
          hum_store = (s.h > 16'd10000) ? HUM_MAX : s.h[13:0];
        end else begin
          temp_store = TEMP_NONE;
          hum_store = '0;
        end
      end
      default: ;
    endcase

    v = vol;
    if (v < 3'd1) v = 3'd1;
    if (v > 3'd5) v = 3'd5;
    if (chime == CHIME_RING || (chime == CHIME_IDLE && alarm_run && beep_high))
      duty = reg_duty[(v - 1) * 8 +: 8];
    else
      duty = '0;

    n = (tx.size() > 0) ? tx.size() : 1;
    for (int k = 0; k < n; k++) begin
      r.tx_valid = (tx.size() > 0);
      r.tx_byte = (tx.size() > 0) ? tx[k] : 8'h00;
      r.last = (k == n - 1);
      r.duty = duty;
      r.alarm = alarm_run;
      reply_q.push_back(r);
    end
  endtask

  task automatic send_item(input stim_t s);
    int     gap;
    int     first;
    reply_t r;
    gap = steady_tx ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= s.op;
    rx_byte_i <= s.b;
    sensor_ok_i <= s.ok;
    temp_centi_i <= s.t;
    hum_centi_i <= s.h;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    first = reply_q.size();
    controller_step(s);
    if (s.typed) begin
      r = reply_q[first];
      r.tx_valid = s.want.tx_valid;
      r.tx_byte = s.want.tx_byte;
      r.duty = s.want.duty;
      r.alarm = s.want.alarm;
      reply_q[first] = r;
    end
  endtask

  task automatic send_plain(input logic [1:0] op, input logic [7:0] b);
    stim_t s;
    s.op = op;
    s.b = b;
    s.ok = 1'($urandom);
    s.t = 16'($urandom);
    s.h = 16'($urandom);
    s.typed = 1'b0;
    s.want = '0;
    send_item(s);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] b, input logic ok,
                         input logic [15:0] t, input logic [15:0] h, input logic typed,
                         input logic tv, input logic [7:0] tb, input logic [7:0] duty,
                         input logic alarm);
    stim_t s;
    s.op = op;
    s.b = b;
    s.ok = ok;
    s.t = t;
    s.h = h;
    s.typed = typed;
    s.want = '{tx_valid: tv, tx_byte: tb, last: 1'b0, duty: duty, alarm: alarm};
    script.push_back(s);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BEEP_ON:   reg_beep_on = data[15:0];
      CFG_BEEP_OFF:  reg_beep_off = data[15:0];
      CFG_ALARM_MAX: reg_alarm_max = data[19:0];
      CFG_HELLO:     reg_hello = data[15:0];
      CFG_DUTY:      reg_duty = data;
      CFG_CHIME_ON:  reg_chime_on = data[7:0];
      CFG_CHIME_OFF: reg_chime_off = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] on_t, input logic [15:0] off_t,
                               input logic [19:0] amax, input logic [15:0] hello,
                               input logic [39:0] duty, input logic [7:0] c_on,
                               input logic [7:0] c_off);
    drain_replies();
    repeat (6) @(posedge clk_i);
    write_reg(CFG_BEEP_ON, 40'(on_t));
    write_reg(CFG_BEEP_OFF, 40'(off_t));
    write_reg(CFG_ALARM_MAX, 40'(amax));
    write_reg(CFG_HELLO, 40'(hello));
    write_reg(CFG_DUTY, duty);
    write_reg(CFG_CHIME_ON, 40'(c_on));
    write_reg(CFG_CHIME_OFF, 40'(c_off));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_traffic(input int target);
    int         start_cnt;
    int         pick;
    logic [7:0] c;
    stim_t      s;
    start_cnt = items_sent;
    while (items_sent - start_cnt < target) begin
      steady_tx = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) drain_replies();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0: c = CMD_START;
          6: c = CMD_STOP;
          7: c = CMD_CHIME;
          8: c = CMD_PING;
          9: c = CMD_READ;
          default: c = 8'($urandom_range(CMD_VOL1, CMD_VOL5));
        endcase
        send_plain(OP_BYTE, SOF_BYTE);
        send_plain(OP_BYTE, c);
        send_plain(OP_BYTE, SOF_BYTE ^ c);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6)) send_plain(OP_TICK, 8'($urandom));
      end else if (pick < 85) begin
        s.op = OP_SENSOR;
        s.b = 8'($urandom);
        s.ok = ($urandom_range(0, 4) != 0);
        s.t = 16'($urandom);
        case ($urandom_range(0, 2))
          0: s.h = 16'($urandom);
          1: s.h = 16'($urandom_range(0, 10000));
          default: s.h = $urandom_range(0, 1) ? 16'd10001 : 16'd10000;
        endcase
        s.typed = 1'b0;
        s.want = '0;
        send_item(s);
      end else begin
        case ($urandom_range(0, 2))
          0: send_plain(OP_BYTE, 8'($urandom));
          1: send_plain(OP_NONE, 8'($urandom));
          default: begin
            c = 8'($urandom);
            send_plain(OP_BYTE, SOF_BYTE);
            send_plain(OP_BYTE, c);
            send_plain(OP_BYTE, SOF_BYTE ^ c ^ (8'd1 << $urandom_range(0, 7)));
          end
        endcase
      end
    end
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 15) == 0) steady_rx = !steady_rx;
        hold = steady_rx ? 0 : $urandom_range(0, 8);
        stall_left <= hold;
        out_stall_i <= (hold != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= (stall_left != 1);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, reply_q.size());
        $display("[uart_buzzer_alarm_controller] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {tx_valid_o, tx_byte_o, last_o, buzzer_duty_o, alarm_on_o};
        if (reply_q.size() == 0) begin
          err_count++;
          $display({"%0t: result with nothing outstanding,",
                    " got tv=%b byte=%h last=%b duty=%h alarm=%b"},
                   $time, got.tx_valid, got.tx_byte, got.last, got.duty, got.alarm);
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (got !== want) begin
            err_count++;
            $display({"%0t: mismatch, expected tv=%b byte=%h last=%b duty=%h alarm=%b,",
                      " got tv=%b byte=%h last=%b duty=%h alarm=%b"},
                     $time, want.tx_valid, want.tx_byte, want.last, want.duty, want.alarm,
                     got.tx_valid, got.tx_byte, got.last, got.duty, got.alarm);
          end
        end
      end
    end
  end

  initial begin
    reg_beep_on = BEEP_ON_RST;
    reg_beep_off = BEEP_OFF_RST;
    reg_alarm_max = ALARM_MAX_RST;
    reg_hello = HELLO_RST;
    reg_duty = DUTY_RST;
    reg_chime_on = CHIME_ON_RST;
    reg_chime_off = CHIME_OFF_RST;
    frame_pos = '0;
    cmd_hold = '0;
    alarm_run = 1'b0;
    beep_high = 1'b0;
    vol = VOL_RST;
    alarm_ticks = '0;
    toggle_ticks = '0;
    hello_ticks = '0;
    hello_first = 1'b1;
    chime = CHIME_IDLE;
    chime_ticks = '0;
    temp_store = TEMP_NONE;
    hum_store = '0;

    // op, byte, ok, temp, hum, typed, tx_valid, tx_byte, duty, alarm
    add_row(OP_TICK, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, SOF_BYTE, 8'h00, 1'b0);
    add_row(OP_SENSOR, 8'hFF, 1'b0, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE ^ CMD_READ, 1'b0, 16'h0000, 16'h0000,
            1'b1, 1'b1, SOF_BYTE, 8'h00, 1'b0);
    add_row(OP_SENSOR, 8'h00, 1'b1, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE ^ CMD_READ, 1'b0, 16'h0000, 16'h0000,
            1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_SENSOR, 8'h00, 1'b1, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_START, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE ^ CMD_START, 1'b0, 16'h0000, 16'h0000,
            1'b1, 1'b1, ACK_BYTE, 8'h50, 1'b1);
    // bad checksum
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_VOL5, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h50, 1'b1);
    // start byte in the command slot is data
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h50, 1'b1);
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_CHIME, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE ^ CMD_CHIME, 1'b0, 16'h0000, 16'h0000,
            1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_TICK, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_NONE, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h50, 1'b1);
    // stop while the chime rings
    add_row(OP_BYTE, SOF_BYTE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, CMD_STOP, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(OP_BYTE, SOF_BYTE ^ CMD_STOP, 1'b0, 16'h0000, 16'h0000,
            1'b1, 1'b1, ACK_BYTE, 8'h50, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_item(script[i]);

    apply_setting(16'd1, 16'd1, 20'd1, 16'd1, 40'h0, 8'd0, 8'd0);
    random_traffic(18);
    apply_setting(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF, 8'hFF, 8'hFF);
    random_traffic(18);
    repeat (3) begin
      apply_setting(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                    20'($urandom_range(3, 40)), 16'($urandom_range(1, 12)),
                    40'({$urandom, $urandom}), 8'($urandom_range(0, 4)),
                    8'($urandom_range(0, 4)));
      random_traffic(18);
    end

    drain_replies();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items (%0d from the directed table) under %0d register settings,",
             items_sent, script.size(), settings_used);
    $display("checked %0d results: frames, ticks, sensor updates and noise.", checked);
    if (err_count == 0)
      $display("[uart_buzzer_alarm_controller] OK");
    else
      $display("[uart_buzzer_alarm_controller] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ubac_pkg.sv
src/uart_buzzer_alarm_controller.sv
src/ubac_checker.sv
bench/tb_uart_buzzer_alarm_controller.sv
